>>> src/mcst_pkg.sv
// Shared types, constants and lookup functions for the MIDI control surface tracker.
package mcst_pkg;

  localparam int CUE_PADS_DEFAULT = 4;
  localparam int PAD_FIELD_W      = 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int LEVEL_W     = 15;
  localparam int CTRL_W      = 5;
  localparam int POS_W       = 7;
  localparam int ELAPSED_W   = 10;
  localparam int LOSS_W      = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_PORT_FILTER = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PORT_SELECT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECK_A_CH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECK_B_CH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIXER_CH    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_RATE  = 3'd5;

  localparam logic [3:0]  DECK_A_CH_RESET  = 4'd0;
  localparam logic [3:0]  DECK_B_CH_RESET  = 4'd1;
  localparam logic [3:0]  MIXER_CH_RESET   = 4'd5;
  localparam logic [19:0] DECAY_RATE_RESET = 20'd260096;

  localparam logic [1:0] KIND_CC       = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;

  localparam int         KNOBS        = 7;
  localparam logic [6:0] JOG_CC       = 7'd32;
  localparam logic [6:0] XFADER_CC    = 7'd10;
  localparam int         HOT_CUE_BASE = 40;
  localparam int         FLASH_SHIFT  = 8;

  localparam logic [CTRL_W-1:0] CTRL_JOG    = 5'd7;
  localparam logic [CTRL_W-1:0] CTRL_FLAG0  = 5'd8;
  localparam logic [CTRL_W-1:0] CTRL_CUE0   = 5'd12;
  localparam logic [CTRL_W-1:0] CTRL_XFADER = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOSS,
    ST_WALK
  } seq_state_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_PLAIN,
    ACT_JOG,
    ACT_CUE
  } act_kind_t;

  typedef enum logic {
    ALU_SAT_SUB,
    ALU_WRAP_ADD
  } alu_op_t;

  // Decoded message: what to update and what to report.
  typedef struct packed {
    act_kind_t               kind;
    logic                    deck;
    logic [CTRL_W-1:0]       control;
    logic [LEVEL_W-1:0]      level;
    logic [PAD_FIELD_W-1:0]  pad;
  } action_t;

  function automatic logic [6:0] knob_cc(input int i);
    case (i)
      0:       knob_cc = 7'd19;
      1:       knob_cc = 7'd23;
      2:       knob_cc = 7'd27;
      3:       knob_cc = 7'd8;
      4:       knob_cc = 7'd21;
      5:       knob_cc = 7'd7;
      default: knob_cc = 7'd0;
    endcase
  endfunction

  function automatic logic [6:0] flag_note(input int i);
    case (i)
      0:       flag_note = 7'd11;
      1:       flag_note = 7'd12;
      2:       flag_note = 7'd13;
      default: flag_note = 7'd16;
    endcase
  endfunction

endpackage

>>> src/mcst_alu.sv
// Shared arithmetic unit: saturating flash decay subtract and wrapping jog add.
module mcst_alu
  import mcst_pkg::*;
(
  input  alu_op_t             op,
  input  logic [LEVEL_W-1:0]  a,
  input  logic [LOSS_W-1:0]   b,
  output logic [LEVEL_W-1:0]  y
);

  logic [LOSS_W-1:0] a_ext;
  logic [LOSS_W-1:0] diff;
  logic [POS_W-1:0]  pos_sum;

  assign a_ext   = LOSS_W'(a);
  assign diff    = a_ext - b;
  assign pos_sum = a[POS_W-1:0] + b[POS_W-1:0];

  always_comb begin
    case (op)
      ALU_SAT_SUB:  y = (a_ext > b) ? diff[LEVEL_W-1:0] : '0;
      ALU_WRAP_ADD: y = LEVEL_W'(pos_sum);
      default:      y = '0;
    endcase
  end

endmodule

>>> src/mcst_msg_decode.sv
// Message decoder: port filter, deck selection and control mapping.
module mcst_msg_decode
  import mcst_pkg::*;
#(
  parameter int CUE_PADS = CUE_PADS_DEFAULT
) (
  input  logic        port_filter_enable,
  input  logic [3:0]  port_select,
  input  logic [3:0]  deck_a_channel,
  input  logic [3:0]  deck_b_channel,
  input  logic [3:0]  mixer_channel,
  input  logic [3:0]  port,
  input  logic [1:0]  message_kind,
  input  logic [3:0]  channel,
  input  logic [6:0]  number,
  input  logic [6:0]  amount,
  output action_t     act
);

  logic drop;
  logic hit_a;
  logic hit_b;
  logic on_note;
  logic knob_hit;
  logic [2:0] knob_idx;
  logic flag_hit;
  logic [1:0] flag_idx;
  logic cue_hit;
  logic [7:0] num_ext;

  assign drop    = port_filter_enable && (port != port_select);
  assign hit_a   = (channel == deck_a_channel);
  assign hit_b   = (channel == deck_b_channel);
  assign on_note = (message_kind == KIND_NOTE_ON) && (amount != 7'd0);
  assign num_ext = {1'b0, number};
  assign cue_hit = (num_ext >= 8'(HOT_CUE_BASE)) && (num_ext < 8'(HOT_CUE_BASE + CUE_PADS));

  always_comb begin
    knob_hit = 1'b0;
    knob_idx = '0;
    for (int i = KNOBS - 1; i >= 0; i--) begin
      if (number == knob_cc(i)) begin
        knob_hit = 1'b1;
        knob_idx = 3'(i);
      end
    end
    flag_hit = 1'b0;
    flag_idx = '0;
    for (int i = 3; i >= 0; i--) begin
      if (number == flag_note(i)) begin
        flag_hit = 1'b1;
        flag_idx = 2'(i);
      end
    end
  end

  always_comb begin
    act.kind    = ACT_NONE;
    act.deck    = hit_a ? 1'b0 : 1'b1;
    act.control = '0;
    act.level   = LEVEL_W'(amount);
    act.pad     = PAD_FIELD_W'(number - 7'(HOT_CUE_BASE));
    if (!drop) begin
      if (message_kind == KIND_CC) begin
        if (!hit_a && !hit_b) begin
          if ((channel == mixer_channel) && (number == XFADER_CC)) begin
            act.kind    = ACT_PLAIN;
            act.deck    = 1'b0;
            act.control = CTRL_XFADER;
          end
        end else if (knob_hit) begin
          act.kind    = ACT_PLAIN;
          act.control = CTRL_W'(knob_idx);
        end else if (number == JOG_CC) begin
          act.kind    = ACT_JOG;
          act.control = CTRL_JOG;
        end
      end else if ((message_kind == KIND_NOTE_ON) || (message_kind == KIND_NOTE_OFF)) begin
        if (hit_a || hit_b) begin
          if (flag_hit) begin
            act.kind    = ACT_PLAIN;
            act.control = CTRL_FLAG0 + CTRL_W'(flag_idx);
            act.level   = LEVEL_W'(on_note);
          end else if (cue_hit) begin
            act.kind    = ACT_CUE;
            act.control = CTRL_CUE0 + CTRL_W'(act.pad);
            act.level   = on_note ? (LEVEL_W'(amount) << FLASH_SHIFT) : '0;
          end
        end
      end
    end
  end

endmodule

>>> src/midi_control_surface_tracker.sv
// Top level of the two-deck MIDI control surface tracker with its sequencer.
//
// The tracker takes decoded MIDI messages and time ticks and keeps the
// controller state that the results depend on: the jog position of each deck
// and the hot-cue flash level of each pad. A message is captured, then
// decoded in the decode state, and gives at most one result; the decode
// state waits while the output register is full and stalled. A tick first
// forms the flash loss, the decay rate times the elapsed time over 1024, in
// a registered multiply step, and then walks the 2 * CUE_PADS flash entries
// through one shared saturating subtract unit, one entry and one result per
// cycle while the output register is free, deck 0 first, with the last
// result marked. The input stall is low only while the sequencer is idle.
// Knob levels, transport flags and the crossfader are reported at the moment
// they are written, so no copy of them is kept. Configuration writes are
// taken in any cycle and must only be issued while the block is idle.
module midi_control_surface_tracker
  import mcst_pkg::*;
#(
  parameter int CUE_PADS = CUE_PADS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port.
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [3:0]             in_port,
  input  logic [1:0]             in_message_kind,
  input  logic [3:0]             in_channel,
  input  logic [6:0]             in_number,
  input  logic [6:0]             in_amount,
  input  logic [ELAPSED_W-1:0]   in_elapsed,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_deck,
  output logic [CTRL_W-1:0]      out_control,
  output logic [LEVEL_W-1:0]     out_level,
  output logic                   out_last
);

  localparam int ENTRIES = 2 * CUE_PADS;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAD_W   = (CUE_PADS > 1) ? $clog2(CUE_PADS) : 1;

  // Configuration registers.
  logic              port_filter_enable_r;
  logic [3:0]        port_select_r;
  logic [3:0]        deck_a_channel_r;
  logic [3:0]        deck_b_channel_r;
  logic [3:0]        mixer_channel_r;
  logic [19:0]       flash_decay_rate_r;

  // Captured input item.
  logic [3:0]           port_r;
  logic [1:0]           kind_r;
  logic [3:0]           channel_r;
  logic [6:0]           number_r;
  logic [6:0]           amount_r;
  logic [ELAPSED_W-1:0] elapsed_r;

  // Tracked state.
  logic [POS_W-1:0]   jog_r   [2];
  logic [LEVEL_W-1:0] flash_r [ENTRIES];
  logic [LOSS_W-1:0]  loss_r;

  // Sequencer.
  seq_state_t      state_r, state_nxt;
  logic            walk_deck_r;
  logic [PAD_W-1:0] walk_pad_r;
  logic            walk_end;
  logic [IDX_W-1:0] walk_idx;
  logic [IDX_W-1:0] cue_idx;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_deck_r;
  logic [CTRL_W-1:0]  out_control_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_last_r;

  logic    slot_free;
  logic    in_xfer;
  action_t act;
  alu_op_t alu_op;
  logic [LEVEL_W-1:0] alu_a;
  logic [LOSS_W-1:0]  alu_b;
  logic [LEVEL_W-1:0] alu_y;
  logic [29:0]        loss_full;

  // Sequencer strobes.
  logic do_capture;
  logic do_loss;
  logic do_walk;
  logic do_msg;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;

  assign walk_end = walk_deck_r && (walk_pad_r == PAD_W'(CUE_PADS - 1));
  assign walk_idx = IDX_W'(int'(walk_deck_r) * CUE_PADS + int'(walk_pad_r));
  assign cue_idx  = IDX_W'(int'(act.deck) * CUE_PADS + int'(act.pad[PAD_W-1:0]));

  mcst_msg_decode #(
    .CUE_PADS (CUE_PADS)
  ) u_decode (
    .port_filter_enable (port_filter_enable_r),
    .port_select        (port_select_r),
    .deck_a_channel     (deck_a_channel_r),
    .deck_b_channel     (deck_b_channel_r),
    .mixer_channel      (mixer_channel_r),
    .port               (port_r),
    .message_kind       (kind_r),
    .channel            (channel_r),
    .number             (number_r),
    .amount             (amount_r),
    .act                (act)
  );

  // The shared unit decays a flash entry during a walk and steps the jog
  // position when a message is applied.
  always_comb begin
    if (state_r == ST_WALK) begin
      alu_op = ALU_SAT_SUB;
      alu_a  = flash_r[walk_idx];
      alu_b  = loss_r;
    end else begin
      alu_op = ALU_WRAP_ADD;
      alu_a  = LEVEL_W'(jog_r[act.deck]);
      alu_b  = LOSS_W'(amount_r);
    end
  end

  mcst_alu u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  assign loss_full = flash_decay_rate_r * elapsed_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = in_cmd ? ST_LOSS : ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((act.kind == ACT_NONE) || slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_LOSS: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (slot_free && walk_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    do_capture = 1'b0;
    do_loss    = 1'b0;
    do_walk    = 1'b0;
    do_msg     = 1'b0;
    case (state_r)
      ST_IDLE:   do_capture = in_xfer;
      ST_DECODE: do_msg     = (act.kind != ACT_NONE) && slot_free;
      ST_LOSS:   do_loss    = 1'b1;
      ST_WALK:   do_walk    = slot_free;
      default:   do_capture = 1'b0;
    endcase
  end

  always_comb begin
    if (do_walk || do_msg) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state, configuration and tracked state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      out_valid_r          <= 1'b0;
      walk_deck_r          <= 1'b0;
      walk_pad_r           <= '0;
      port_filter_enable_r <= 1'b0;
      port_select_r        <= '0;
      deck_a_channel_r     <= DECK_A_CH_RESET;
      deck_b_channel_r     <= DECK_B_CH_RESET;
      mixer_channel_r      <= MIXER_CH_RESET;
      flash_decay_rate_r   <= DECAY_RATE_RESET;
      for (int d = 0; d < 2; d++) begin
        jog_r[d] <= '0;
      end
      for (int e = 0; e < ENTRIES; e++) begin
        flash_r[e] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_PORT_FILTER: port_filter_enable_r <= cfg_wdata[0];
          CFG_PORT_SELECT: port_select_r        <= cfg_wdata[3:0];
          CFG_DECK_A_CH:   deck_a_channel_r     <= cfg_wdata[3:0];
          CFG_DECK_B_CH:   deck_b_channel_r     <= cfg_wdata[3:0];
          CFG_MIXER_CH:    mixer_channel_r      <= cfg_wdata[3:0];
          CFG_DECAY_RATE:  flash_decay_rate_r   <= cfg_wdata[19:0];
          default:         port_filter_enable_r <= port_filter_enable_r;
        endcase
      end
      if (do_loss) begin
        walk_deck_r <= 1'b0;
        walk_pad_r  <= '0;
      end
      if (do_walk) begin
        flash_r[walk_idx] <= alu_y;
        if (walk_pad_r == PAD_W'(CUE_PADS - 1)) begin
          walk_pad_r  <= '0;
          walk_deck_r <= 1'b1;
        end else begin
          walk_pad_r <= walk_pad_r + PAD_W'(1);
        end
      end
      if (do_msg) begin
        case (act.kind)
          ACT_JOG: jog_r[act.deck]  <= alu_y[POS_W-1:0];
          ACT_CUE: flash_r[cue_idx] <= act.level;
          default: jog_r[act.deck]  <= jog_r[act.deck];
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (do_capture) begin
      port_r    <= in_port;
      kind_r    <= in_message_kind;
      channel_r <= in_channel;
      number_r  <= in_number;
      amount_r  <= in_amount;
      elapsed_r <= in_elapsed;
    end
    if (do_loss) begin
      loss_r <= loss_full[29:10];
    end
    if (do_walk) begin
      out_deck_r    <= walk_deck_r;
      out_control_r <= CTRL_CUE0 + CTRL_W'(walk_pad_r);
      out_level_r   <= alu_y;
      out_last_r    <= walk_end;
    end else if (do_msg) begin
      out_deck_r    <= act.deck;
      out_control_r <= act.control;
      out_level_r   <= (act.kind == ACT_JOG) ? alu_y : act.level;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_deck    = out_deck_r;
  assign out_control = out_control_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;

endmodule

>>> verif/tb_midi_control_surface_tracker.sv
// Self-checking testbench for the two-deck MIDI control surface tracker.
module tb_midi_control_surface_tracker
  import mcst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The cycle limit is several times the slowest correct run: about
  // 380 inputs, each up to eight results behind a randomly stalling receiver,
  // plus the long receiver hold-off and the quiet gaps between phases.
  localparam int          PADS          = CUE_PADS_DEFAULT;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          HOLD_CYCLES   = 150;
  localparam int          PHASE_ITEMS   = 90;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  // Input command and message kind codes that the package does not name.
  localparam logic       CMD_MESSAGE = 1'b0;
  localparam logic       CMD_TICK    = 1'b1;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  // Register index outside the register file; a write there must do nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 3'd7;

  // Controller numbers of the seven knobs, in control order, and the notes of
  // the four transport flags (play, cue, sync, loop).
  localparam logic [6:0] KNOB_NUMS [KNOBS] = '{7'd19, 7'd23, 7'd27, 7'd8, 7'd21, 7'd7, 7'd0};
  localparam logic [6:0] FLAG_NOTES [4]    = '{7'd11, 7'd12, 7'd13, 7'd16};

  typedef struct packed {
    logic                 cmd;
    logic [3:0]           port;
    logic [1:0]           kind;
    logic [3:0]           channel;
    logic [6:0]           number;
    logic [6:0]           amount;
    logic [ELAPSED_W-1:0] elapsed;
  } midi_item_t;

  typedef struct packed {
    logic               deck;
    logic [CTRL_W-1:0]  control;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } report_t;

  // Mirror of the tracker: register copy, jog positions and flash levels, and
  // the queue of reports that accepted inputs are owed. Knob levels, flags and
  // the crossfader are reported exactly as written, so nothing downstream
  // depends on remembering them.
  class surface_scoreboard;
    logic                  filter_on;
    logic [3:0]            port_sel;
    logic [3:0]            deck_a_ch;
    logic [3:0]            deck_b_ch;
    logic [3:0]            mixer_ch;
    logic [CFG_DATA_W-1:0] decay_rate;
    logic [6:0]            jog_pos [2];
    logic [LEVEL_W-1:0]    flash [2*PADS];
    report_t               pending_reports [$];
    int unsigned           mismatches;
    int unsigned           reports_seen;

    function new();
      filter_on  = 1'b0;
      port_sel   = 4'd0;
      deck_a_ch  = DECK_A_CH_RESET;
      deck_b_ch  = DECK_B_CH_RESET;
      mixer_ch   = MIXER_CH_RESET;
      decay_rate = DECAY_RATE_RESET;
      jog_pos    = '{7'd0, 7'd0};
      foreach (flash[i]) flash[i] = '0;
      mismatches   = 0;
      reports_seen = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PORT_FILTER: filter_on  = data[0];
        CFG_PORT_SELECT: port_sel   = data[3:0];
        CFG_DECK_A_CH:   deck_a_ch  = data[3:0];
        CFG_DECK_B_CH:   deck_b_ch  = data[3:0];
        CFG_MIXER_CH:    mixer_ch   = data[3:0];
        CFG_DECAY_RATE:  decay_rate = data;
        default: ;
      endcase
    endfunction

    function void owe_report(logic deck, logic [CTRL_W-1:0] control,
                             logic [LEVEL_W-1:0] level, logic last);
      pending_reports.push_back('{deck, control, level, last});
    endfunction

    // Works out the reports that one accepted input causes.
    function void note_input(midi_item_t it);
      int                     deck;
      int                     num;
      logic                   on;
      logic [29:0]            product;
      logic [LOSS_W-1:0]      loss;
      if (it.cmd == CMD_TICK) begin
        // Loss is rate times elapsed over 1024; each flash level saturates at
        // zero, and all pads are reported, deck 0 first.
        product = 30'(decay_rate) * 30'(it.elapsed);
        loss    = product[29:10];
        for (int i = 0; i < 2 * PADS; i++) begin
          if (20'(flash[i]) > loss) flash[i] = 15'(20'(flash[i]) - loss);
          else flash[i] = '0;
          owe_report(i >= PADS, CTRL_CUE0 + 5'(i % PADS), flash[i], i == 2 * PADS - 1);
        end
        return;
      end
      if (filter_on && it.port != port_sel) return;
      // Deck A wins when both deck channels are the same.
      if (it.channel == deck_a_ch) deck = 0;
      else if (it.channel == deck_b_ch) deck = 1;
      else deck = -1;
      num = int'(it.number);
      if (it.kind == KIND_CC) begin
        if (deck < 0) begin
          if (it.channel == mixer_ch && it.number == XFADER_CC)
            owe_report(1'b0, CTRL_XFADER, 15'(it.amount), 1'b1);
          return;
        end
        for (int k = 0; k < KNOBS; k++) begin
          if (it.number == KNOB_NUMS[k]) begin
            owe_report(1'(deck), 5'(k), 15'(it.amount), 1'b1);
            return;
          end
        end
        // The jog position wraps modulo 128, so 65-127 step backward.
        if (it.number == JOG_CC) begin
          jog_pos[deck] = jog_pos[deck] + it.amount;
          owe_report(1'(deck), CTRL_JOG, 15'(jog_pos[deck]), 1'b1);
        end
      end else if (it.kind == KIND_NOTE_ON || it.kind == KIND_NOTE_OFF) begin
        // A note on with zero velocity counts as a note off.
        on = (it.kind == KIND_NOTE_ON) && (it.amount != 7'd0);
        if (deck < 0) return;
        for (int f = 0; f < 4; f++) begin
          if (it.number == FLAG_NOTES[f]) begin
            owe_report(1'(deck), CTRL_FLAG0 + 5'(f), 15'(on), 1'b1);
            return;
          end
        end
        if (num >= HOT_CUE_BASE && num < HOT_CUE_BASE + PADS) begin
          flash[deck * PADS + num - HOT_CUE_BASE] = on ? (15'(it.amount) << FLASH_SHIFT) : '0;
          owe_report(1'(deck), CTRL_CUE0 + 5'(num - HOT_CUE_BASE),
                     flash[deck * PADS + num - HOT_CUE_BASE], 1'b1);
        end
      end
    endfunction

    // Compares one accepted report with the oldest one owed.
    function void check_report(report_t got);
      report_t want;
      reports_seen++;
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result deck %0d control %0d level %0d last %0d",
                 $time, got.deck, got.control, got.level, got.last);
        return;
      end
      want = pending_reports.pop_front();
      if (got.deck !== want.deck || got.control !== want.control ||
          got.level !== want.level || got.last !== want.last) begin
        mismatches++;
        $display("%0t: result mismatch: expected deck %0d control %0d level %0d last %0d,",
                 $time, want.deck, want.control, want.level, want.last);
        $display("    actual deck %0d control %0d level %0d last %0d",
                 got.deck, got.control, got.level, got.last);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_cmd;
  logic [3:0]             in_port;
  logic [1:0]             in_message_kind;
  logic [3:0]             in_channel;
  logic [6:0]             in_number;
  logic [6:0]             in_amount;
  logic [ELAPSED_W-1:0]   in_elapsed;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_deck;
  logic [CTRL_W-1:0]      out_control;
  logic [LEVEL_W-1:0]     out_level;
  logic                   out_last;

  surface_scoreboard sb = new();

  // Shared between the stimulus process and the receiver: quiet turns off all
  // random idling, hold_req asks the receiver for one long hold-off.
  bit          quiet;
  bit          hold_req;
  int unsigned inputs_sent;
  int unsigned ticks_sent;
  int unsigned cycle_count;

  midi_control_surface_tracker #(.CUE_PADS(PADS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_port         (in_port),
    .in_message_kind (in_message_kind),
    .in_channel      (in_channel),
    .in_number       (in_number),
    .in_amount       (in_amount),
    .in_elapsed      (in_elapsed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_deck        (out_deck),
    .out_control     (out_control),
    .out_level       (out_level),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles with %0d results still owed",
                 cycle_count, sb.pending_reports.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver. Unless quiet is set, it stalls at random with a chance of 23 in 100, and on
  // request holds the output off for a long counted stretch so that the block
  // backs up and stalls its input.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  // Result monitor. Outputs are sampled at the clock edge, before any update
  // of that edge lands, so each transfer is seen exactly once.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        sb.check_report(report_t'({out_deck, out_control, out_level, out_last}));
    end
  end

  // Offers one input, idling at random first, and holds the payload steady
  // until the transfer happens; the mirror is told at that edge.
  task automatic offer(midi_item_t it);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= it.cmd;
    in_port         <= it.port;
    in_message_kind <= it.kind;
    in_channel      <= it.channel;
    in_number       <= it.number;
    in_amount       <= it.amount;
    in_elapsed      <= it.elapsed;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
    inputs_sent++;
    if (it.cmd == CMD_TICK) ticks_sent++;
  endtask

  // Stops sending until every owed result has arrived, then lets the block
  // finish any message that causes no result.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Writes the whole register file plus an unused index; the block is idle.
  task automatic load_settings(logic filter, logic [3:0] psel, logic [3:0] a_ch,
                               logic [3:0] b_ch, logic [3:0] mix_ch,
                               logic [CFG_DATA_W-1:0] rate);
    write_reg(CFG_PORT_FILTER, 20'(filter));
    write_reg(CFG_PORT_SELECT, 20'(psel));
    write_reg(CFG_DECK_A_CH, 20'(a_ch));
    write_reg(CFG_DECK_B_CH, 20'(b_ch));
    write_reg(CFG_MIXER_CH, 20'(mix_ch));
    write_reg(CFG_DECAY_RATE, rate);
    write_reg(CFG_SPARE, 20'($urandom_range(1048575)));
    cfg_we <= 1'b0;
  endtask

  function automatic midi_item_t message(logic [1:0] kind, logic [3:0] ch,
                                         logic [6:0] num, logic [6:0] amt);
    midi_item_t it;
    it.cmd     = CMD_MESSAGE;
    it.port    = 4'($urandom_range(15));
    it.kind    = kind;
    it.channel = ch;
    it.number  = num;
    it.amount  = amt;
    it.elapsed = 10'($urandom_range(1023));
    return it;
  endfunction

  // A tick carries random message fields, which the block must ignore.
  function automatic midi_item_t tick(logic [ELAPSED_W-1:0] elapsed);
    midi_item_t it;
    it         = message(2'($urandom_range(3)), 4'($urandom_range(15)),
                         7'($urandom_range(127)), 7'($urandom_range(127)));
    it.cmd     = CMD_TICK;
    it.elapsed = elapsed;
    return it;
  endfunction

  // Random input aimed at the mapped controls of the current settings, with
  // some unmapped numbers, stray channels and filtered ports mixed in.
  function automatic midi_item_t random_item();
    midi_item_t it;
    int         r;
    it = message(2'($urandom_range(3)), 4'($urandom_range(15)),
                 7'($urandom_range(127)), 7'($urandom_range(127)));
    r = $urandom_range(99);
    if (r < 45) it.kind = KIND_CC;
    else if (r < 72) it.kind = KIND_NOTE_ON;
    else if (r < 92) it.kind = KIND_NOTE_OFF;
    else it.kind = KIND_OTHER;
    if ($urandom_range(3) != 0) it.port = sb.port_sel;
    case ($urandom_range(5))
      0, 1: it.channel = sb.deck_a_ch;
      2, 3: it.channel = sb.deck_b_ch;
      4:    it.channel = sb.mixer_ch;
      default: ;
    endcase
    r = $urandom_range(11);
    if (it.kind == KIND_CC) begin
      if (r < KNOBS) it.number = KNOB_NUMS[r];
      else if (r < 9) it.number = JOG_CC;
      else if (r == 9) it.number = XFADER_CC;
    end else begin
      if (r < 4) it.number = FLAG_NOTES[r];
      else if (r < 8) it.number = 7'(HOT_CUE_BASE + r - 4);
      else if (r == 8) it.number = 7'(HOT_CUE_BASE + PADS);
    end
    case ($urandom_range(7))
      0: it.amount = 7'd0;
      1: it.amount = 7'd127;
      2: it.amount = 7'd64;
      default: ;
    endcase
    case ($urandom_range(7))
      0: it.elapsed = '0;
      1: it.elapsed = '1;
      default: ;
    endcase
    if ($urandom_range(99) < 18) it.cmd = CMD_TICK;
    return it;
  endfunction

  task automatic random_run(int count);
    for (int n = 0; n < count; n++) offer(random_item());
  endtask

  initial begin
    quiet           = 1'b0;
    hold_req        = 1'b0;
    inputs_sent     = 0;
    ticks_sent      = 0;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_PORT_FILTER;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_MESSAGE;
    in_port         <= '0;
    in_message_kind <= KIND_CC;
    in_channel      <= '0;
    in_number       <= '0;
    in_amount       <= '0;
    in_elapsed      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings: deck A on channel 0, deck B on 1,
    // the mixer on 5, no port filtering and the default decay rate.
    // Every knob, alternating decks and level extremes.
    for (int k = 0; k < KNOBS; k++)
      offer(message(KIND_CC, (k % 2 == 0) ? DECK_A_CH_RESET : DECK_B_CH_RESET,
                    KNOB_NUMS[k], (k % 2 == 0) ? 7'd0 : 7'd127));
    // Jog: one step forward, one step back to zero, a step back through the
    // wrap, half a turn, no motion, and the smallest backward value.
    offer(message(KIND_CC, DECK_A_CH_RESET, JOG_CC, 7'd1));
    offer(message(KIND_CC, DECK_A_CH_RESET, JOG_CC, 7'd127));
    offer(message(KIND_CC, DECK_A_CH_RESET, JOG_CC, 7'd127));
    offer(message(KIND_CC, DECK_B_CH_RESET, JOG_CC, 7'd64));
    offer(message(KIND_CC, DECK_B_CH_RESET, JOG_CC, 7'd0));
    offer(message(KIND_CC, DECK_B_CH_RESET, JOG_CC, 7'd65));
    // Crossfader on the mixer channel; the same number on a deck is unmapped.
    offer(message(KIND_CC, MIXER_CH_RESET, XFADER_CC, 7'd127));
    offer(message(KIND_CC, DECK_A_CH_RESET, XFADER_CC, 7'd55));
    // Transport flags, including a note on with zero velocity.
    offer(message(KIND_NOTE_ON, DECK_A_CH_RESET, FLAG_NOTES[0], 7'd127));
    offer(message(KIND_NOTE_ON, DECK_B_CH_RESET, FLAG_NOTES[1], 7'd0));
    offer(message(KIND_NOTE_OFF, DECK_A_CH_RESET, FLAG_NOTES[2], 7'd64));
    offer(message(KIND_NOTE_ON, DECK_B_CH_RESET, FLAG_NOTES[3], 7'd1));
    // Hot cues at both ends of the pad range and the note just past it.
    offer(message(KIND_NOTE_ON, DECK_A_CH_RESET, 7'(HOT_CUE_BASE), 7'd127));
    offer(message(KIND_NOTE_ON, DECK_B_CH_RESET, 7'(HOT_CUE_BASE + PADS - 1), 7'd1));
    offer(message(KIND_NOTE_ON, DECK_A_CH_RESET, 7'(HOT_CUE_BASE + PADS), 7'd100));
    // A short tick decays only partly; even the last pad keeps a small level.
    offer(tick(10'd1));
    // Ignored traffic: another message kind, a note on the mixer channel and
    // a message on a channel that nothing listens to.
    offer(message(KIND_OTHER, DECK_A_CH_RESET, 7'(HOT_CUE_BASE + 1), 7'd90));
    offer(message(KIND_NOTE_ON, MIXER_CH_RESET, FLAG_NOTES[0], 7'd127));
    offer(message(KIND_CC, 4'd9, KNOB_NUMS[0], 7'd33));
    // Releasing a cue clears its flash; the longest tick empties the rest.
    offer(message(KIND_NOTE_OFF, DECK_A_CH_RESET, 7'(HOT_CUE_BASE), 7'd127));
    offer(tick('1));

    // Port filter on the top port, channels at the extremes, fastest decay.
    settle_idle();
    load_settings(1'b1, 4'd15, 4'd15, 4'd0, 4'd7, '1);
    random_run(PHASE_ITEMS);

    // Both decks and the mixer on one channel, no decay; no idling anywhere.
    settle_idle();
    load_settings(1'b0, 4'd0, 4'd3, 4'd3, 4'd3, '0);
    quiet = 1'b1;
    random_run(PHASE_ITEMS);
    quiet = 1'b0;

    // Random channels and a slow decay so flash levels fade over several
    // ticks. Halfway through, the receiver holds off while inputs keep coming.
    settle_idle();
    load_settings(1'b1, 4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)),
                  20'($urandom_range(4095)));
    random_run(PHASE_ITEMS / 2);
    hold_req = 1'b1;
    random_run(PHASE_ITEMS / 2);

    // Everything random, decay rate included.
    settle_idle();
    load_settings(1'($urandom_range(1)), 4'($urandom_range(15)), 4'($urandom_range(15)),
                  4'($urandom_range(15)), 4'($urandom_range(15)),
                  20'($urandom_range(1048575)));
    random_run(PHASE_ITEMS);

    settle_idle();
    $display("Sent %0d inputs (%0d ticks) over five register settings, with a long",
             inputs_sent, ticks_sent);
    $display("output hold-off and a quiet phase; %0d results checked, %0d mismatched.",
             sb.reports_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/mcst_pkg.sv
src/mcst_alu.sv
src/mcst_msg_decode.sv
src/midi_control_surface_tracker.sv
verif/tb_midi_control_surface_tracker.sv
